/* design/kwsm_pkg.sv */
// Shared types and codes for the k-way sorted record merge.
// No dependencies; used by kwsm_cell and kway_sorted_record_merge.
package kwsm_pkg;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_END    = 1'b1;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam int unsigned COUNT_W = 4;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned DATA_W  = 64;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

  typedef struct packed {
    logic found;
    logic ready;
    logic any_head;
    logic all_ended;
  } scan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

endpackage

/* design/kway_sorted_record_merge.sv */
// Top level of the k-way sorted record merge: slot chain, control and
// output register. Depends on kwsm_pkg and kwsm_cell.
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid / s_axis_tready   tdata: record; tuser: operation, stream_index
//  m_axis   out  m_axis_tvalid / m_axis_tready   tdata: merged_record; tuser: kind, source_stream
//  cfg      in   cfg_we                          cfg_wdata: stream_count
//
// A good word starts a search pass down the chain of MAX_STREAMS cells, one cell a
// cycle; its result goes through the pending register into the output register.
// The next word is taken when the pass ends without a result, or else once the result
// is loaded. An error word skips the pass: its result goes to the pending register.
// A result held back by m_axis_tready waits in the pending register and blocks input.
// rst is synchronous and clears all slot flags; no clearing pass is needed.
module kway_sorted_record_merge #(
  parameter int unsigned MAX_STREAMS  = 8,
  parameter int unsigned RECORD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,      // stream_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // record
  input  logic [3:0]  s_axis_tuser,   // operation, stream_index[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // merged_record
  output logic [4:0]  m_axis_tuser    // kind[1:0], source_stream[2:0]
);

  localparam int unsigned IW    = $clog2(MAX_STREAMS);
  localparam int unsigned REC_W = 8 * RECORD_BYTES;
  localparam int unsigned CNT_W = $clog2(MAX_STREAMS + 1);

  kwsm_pkg::state_t state, state_next;

  logic [kwsm_pkg::COUNT_W-1:0] stream_count;
  logic [CNT_W-1:0]             live_n;
  logic                         done_sent;

  logic                          in_op;
  logic [kwsm_pkg::INDEX_W-1:0]  in_idx;
  logic [REC_W-1:0]              in_rec;
  logic                          s_acc;
  logic                          slot_busy;
  logic                          in_err;

  logic [MAX_STREAMS-1:0] hv;
  logic [MAX_STREAMS-1:0] en;

  logic            go    [MAX_STREAMS+1];
  kwsm_pkg::scan_t ctl   [MAX_STREAMS+1];
  logic [IW-1:0]   cidx  [MAX_STREAMS+1];
  logic [REC_W-1:0] crec [MAX_STREAMS+1];

  logic                 start;
  logic                 scan_done;
  kwsm_pkg::scan_t      res;
  logic                 emit_rec;
  logic                 emit_done;
  logic                 pop;
  logic                 out_free;
  logic                 load_out;

  logic [1:0]                   pend_kind;
  logic [kwsm_pkg::INDEX_W-1:0] pend_src;
  logic [REC_W-1:0]             pend_rec;

  logic [1:0]                   out_kind;
  logic [kwsm_pkg::INDEX_W-1:0] out_src;
  logic [REC_W-1:0]             out_rec;
  logic                         out_valid;

  assign in_op  = s_axis_tuser[0];
  assign in_idx = s_axis_tuser[3:1];
  assign in_rec = s_axis_tdata[REC_W-1:0];

  always_comb begin
    if (stream_count == '0) begin
      live_n = CNT_W'(1);
    end else if (32'(stream_count) > MAX_STREAMS) begin
      live_n = CNT_W'(MAX_STREAMS);
    end else begin
      live_n = CNT_W'(stream_count);
    end
  end

  always_comb begin
    slot_busy = 1'b0;
    for (int i = 0; i < MAX_STREAMS; i++) begin
      if (32'(in_idx) == i) begin
        slot_busy = hv[i] | en[i];
      end
    end
  end

  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign in_err = (32'(in_idx) >= 32'(live_n)) || slot_busy;

  assign scan_done = go[MAX_STREAMS];
  assign res       = ctl[MAX_STREAMS];
  assign emit_rec  = scan_done && res.ready && res.any_head && res.found;
  assign emit_done = scan_done && !emit_rec && res.all_ended && !done_sent;
  assign pop       = emit_rec;
  assign out_free  = !out_valid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kwsm_pkg::ST_IDLE: begin
        if (s_acc) begin
          state_next = in_err ? kwsm_pkg::ST_OUT : kwsm_pkg::ST_SCAN;
        end
      end
      kwsm_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = (emit_rec || emit_done) ? kwsm_pkg::ST_OUT : kwsm_pkg::ST_IDLE;
        end
      end
      kwsm_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = kwsm_pkg::ST_IDLE;
        end
      end
      default: state_next = kwsm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      kwsm_pkg::ST_IDLE: s_axis_tready = 1'b1;
      kwsm_pkg::ST_SCAN: ;
      kwsm_pkg::ST_OUT:  load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kwsm_pkg::ST_IDLE;
      stream_count <= kwsm_pkg::COUNT_RESET;
      done_sent    <= 1'b0;
      start        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      start <= s_acc && !in_err;
      if (cfg_we) begin
        stream_count <= cfg_wdata;
        done_sent    <= 1'b0;
      end else if (emit_done) begin
        done_sent <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && in_err) begin
      pend_kind <= kwsm_pkg::KIND_ERROR;
      pend_src  <= in_idx;
      pend_rec  <= '0;
    end else if (emit_rec) begin
      pend_kind <= kwsm_pkg::KIND_RECORD;
      pend_src  <= kwsm_pkg::INDEX_W'(cidx[MAX_STREAMS]);
      pend_rec  <= crec[MAX_STREAMS];
    end else if (emit_done) begin
      pend_kind <= kwsm_pkg::KIND_DONE;
      pend_src  <= '0;
      pend_rec  <= '0;
    end
    if (load_out) begin
      out_kind <= pend_kind;
      out_src  <= pend_src;
      out_rec  <= pend_rec;
    end
  end

  assign go[0]   = start;
  assign ctl[0]  = '{found: 1'b0, ready: 1'b1, any_head: 1'b0, all_ended: 1'b1};
  assign cidx[0] = '0;
  assign crec[0] = '0;

  for (genvar g = 0; g < MAX_STREAMS; g++) begin : g_cell
    kwsm_cell #(
      .IDX   (g),
      .IW    (IW),
      .REC_W (REC_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .clr        (cfg_we),
      .wr         (s_acc && !in_err),
      .wr_op      (in_op),
      .wr_idx     (in_idx),
      .wr_rec     (in_rec),
      .pop        (pop),
      .pop_idx    (cidx[MAX_STREAMS]),
      .live_n     (live_n),
      .in_go      (go[g]),
      .in_ctl     (ctl[g]),
      .in_idx     (cidx[g]),
      .in_rec     (crec[g]),
      .out_go     (go[g+1]),
      .out_ctl    (ctl[g+1]),
      .out_idx    (cidx[g+1]),
      .out_rec    (crec[g+1]),
      .head_valid (hv[g]),
      .ended      (en[g])
    );
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = 64'(out_rec);
  assign m_axis_tuser  = {out_src, out_kind};

endmodule

/* design/kwsm_cell.sv */
// One stream slot: head record, valid and ended flags, and one stage of the
// minimum-search chain. Depends on kwsm_pkg.
module kwsm_cell #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned IW     = 3,
  parameter int unsigned REC_W  = 64,
  parameter int unsigned CNT_W  = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr,
  input  logic                        wr,
  input  logic                        wr_op,
  input  logic [kwsm_pkg::INDEX_W-1:0] wr_idx,
  input  logic [REC_W-1:0]            wr_rec,
  input  logic                        pop,
  input  logic [IW-1:0]               pop_idx,
  input  logic [CNT_W-1:0]            live_n,
  input  logic                        in_go,
  input  kwsm_pkg::scan_t             in_ctl,
  input  logic [IW-1:0]               in_idx,
  input  logic [REC_W-1:0]            in_rec,
  output logic                        out_go,
  output kwsm_pkg::scan_t             out_ctl,
  output logic [IW-1:0]               out_idx,
  output logic [REC_W-1:0]            out_rec,
  output logic                        head_valid,
  output logic                        ended
);

  logic [REC_W-1:0] head_record;
  logic             sel;
  logic             live;
  kwsm_pkg::scan_t  ctl_next;
  logic [IW-1:0]    idx_next;
  logic [REC_W-1:0] rec_next;

  assign sel  = wr && (32'(wr_idx) == IDX);
  assign live = (32'(live_n) > IDX);

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      head_valid <= 1'b0;
      ended      <= 1'b0;
    end else begin
      if (sel && wr_op == kwsm_pkg::OP_RECORD) begin
        head_valid <= 1'b1;
      end else if (pop && (32'(pop_idx) == IDX)) begin
        head_valid <= 1'b0;
      end
      if (sel && wr_op == kwsm_pkg::OP_END) begin
        ended <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr_op == kwsm_pkg::OP_RECORD) begin
      head_record <= wr_rec;
    end
  end

  always_comb begin
    ctl_next = in_ctl;
    idx_next = in_idx;
    rec_next = in_rec;
    if (live) begin
      if (head_valid) begin
        ctl_next.any_head  = 1'b1;
        ctl_next.all_ended = 1'b0;
        // strict less-than keeps the lower index on a tie
        if (!in_ctl.found || head_record < in_rec) begin
          ctl_next.found = 1'b1;
          idx_next       = IW'(IDX);
          rec_next       = head_record;
        end
      end else if (!ended) begin
        ctl_next.ready     = 1'b0;
        ctl_next.all_ended = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_go <= 1'b0;
    end else begin
      out_go <= in_go;
    end
  end

  always_ff @(posedge clk) begin
    out_ctl <= ctl_next;
    out_idx <= idx_next;
    out_rec <= rec_next;
  end

endmodule

/* tb/tb_kway_sorted_record_merge.sv */
// Self-checking testbench for kway_sorted_record_merge: stream-driven record merges
// under several stream counts, predicted by a scoreboard class and checked word by word.
// Depends on kwsm_pkg and the kway_sorted_record_merge RTL.
`timescale 1ns / 100ps

module tb_kway_sorted_record_merge;

  localparam int unsigned ITEMS       = 2000;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned NSLOT       = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  src;
    logic [63:0] rec;
  } merge_word_t;

  class merge_scoreboard;
    logic [63:0] heads [NSLOT];
    bit          head_full [NSLOT];
    bit          ended [NSLOT];
    bit          done_given;
    logic [3:0]  count;
    merge_word_t pending_q [$];
    int unsigned errors;
    int unsigned n_records, n_dones, n_faults;

    function new();
      clear();
      count = kwsm_pkg::COUNT_RESET;
    endfunction

    function void clear();
      for (int i = 0; i < NSLOT; i++) begin
        head_full[i] = 0;
        ended[i]     = 0;
      end
      done_given = 0;
    endfunction

    function void configure(logic [3:0] value);
      count = value;
      clear();
    endfunction

    function int unsigned live();
      if (count == 0) return 1;
      if (count > NSLOT) return NSLOT;
      return count;
    endfunction

    function bit wants(int unsigned s);
      return s < live() && !head_full[s] && !ended[s];
    endfunction

    function void note(logic op, logic [2:0] idx, logic [63:0] rec);
      int unsigned n;
      int          best;
      bit          ready, any_head, all_ended;
      merge_word_t w;
      n = live();
      ready = 1;
      any_head = 0;
      all_ended = 1;
      best = -1;
      if (idx >= n || head_full[idx] || ended[idx]) begin
        w = '{kind: kwsm_pkg::KIND_ERROR, src: idx, rec: '0};
        pending_q.push_back(w);
        return;
      end
      if (op == kwsm_pkg::OP_RECORD) begin
        heads[idx] = rec;
        head_full[idx] = 1;
      end else begin
        ended[idx] = 1;
      end
      for (int i = 0; i < n; i++) begin
        if (head_full[i]) begin
          any_head = 1;
          all_ended = 0;
          if (best < 0 || heads[i] < heads[best]) best = i;
        end else if (!ended[i]) begin
          ready = 0;
          all_ended = 0;
        end
      end
      if (ready && any_head) begin
        head_full[best] = 0;
        w = '{kind: kwsm_pkg::KIND_RECORD, src: 3'(best), rec: heads[best]};
        pending_q.push_back(w);
      end else if (all_ended && !done_given) begin
        done_given = 1;
        w = '{kind: kwsm_pkg::KIND_DONE, src: '0, rec: '0};
        pending_q.push_back(w);
      end
    endfunction

    function void check(logic [1:0] kind, logic [2:0] src, logic [63:0] rec);
      merge_word_t w;
      if (pending_q.size() == 0) begin
        $error("unexpected result word: kind %0d src %0d rec %h", kind, src, rec);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      case (w.kind)
        kwsm_pkg::KIND_RECORD: n_records++;
        kwsm_pkg::KIND_DONE:   n_dones++;
        default:               n_faults++;
      endcase
      if (kind !== w.kind) begin
        $error("kind: expected %0d, got %0d", w.kind, kind);
        errors++;
      end
      if (src !== w.src) begin
        $error("source_stream: expected %0d, got %0d", w.src, src);
        errors++;
      end
      if (rec !== w.rec) begin
        $error("merged_record: expected %h, got %h", w.rec, rec);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // record
  logic [3:0]  s_axis_tuser;   // operation, stream_index[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // merged_record
  logic [4:0]  m_axis_tuser;   // kind[1:0], source_stream[2:0]

  merge_scoreboard sb;
  int unsigned     words_sent;
  int unsigned     cfg_writes;
  int unsigned     quiet;

  kway_sorted_record_merge u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_base();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return 64'($urandom_range(0, 20));
    if (r == 1) return 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(0, 'h40));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] step();
    if ($urandom_range(0, 3) == 0) return 64'd0;
    return 64'($urandom_range(1, 1000));
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note(s_axis_tuser[0], s_axis_tuser[3:1], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check(m_axis_tuser[1:0], m_axis_tuser[4:2], m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) ||
                 (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet + 1 >= QUIET_LIMIT) begin
        $display("tb_kway_sorted_record_merge: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned run_len, stall;
    m_axis_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      m_axis_tready = 1;
      repeat (run_len) @(negedge clk);
      stall = gap_len();
      if (stall > 0) begin
        m_axis_tready = 0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  task automatic send_word(input logic op, input logic [2:0] idx, input logic [63:0] rec);
    s_axis_tvalid = 1;
    s_axis_tdata  = rec;
    s_axis_tuser  = {idx, op};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic rest(input int unsigned n);
    if (n > 0) begin
      s_axis_tvalid = 0;
      repeat (n) @(negedge clk);
    end
  endtask

  // hold off the sender until every predicted word has come out
  task automatic drain();
    s_axis_tvalid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_count(input logic [3:0] value);
    drain();
    cfg_we    = 1;
    cfg_wdata = value;
    sb.configure(value);
    @(negedge clk);
    cfg_we = 0;
    cfg_writes++;
  endtask

  task automatic run_merge(input bit bursty);
    int unsigned left [NSLOT];
    logic [63:0] last [NSLOT];
    int unsigned cands [$];
    int unsigned n, s;
    bit          busy;
    n = sb.live();
    for (int i = 0; i < NSLOT; i++) begin
      left[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      last[i] = pick_base();
    end
    busy = 1;
    while (busy && words_sent < ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        send_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), {$urandom, $urandom});
      end else begin
        cands.delete();
        for (int i = 0; i < n; i++)
          if (sb.wants(i)) cands.push_back(i);
        if (cands.size() == 0) begin
          busy = 0;
        end else begin
          s = cands[$urandom_range(0, cands.size() - 1)];
          if (left[s] > 0 && $urandom_range(0, 49) != 0) begin
            last[s] = last[s] + step();
            left[s]--;
            send_word(kwsm_pkg::OP_RECORD, 3'(s), last[s]);
          end else begin
            left[s] = 0;
            send_word(kwsm_pkg::OP_END, 3'(s), {$urandom, $urandom});
          end
        end
      end
      if (busy) rest(bursty ? 0 : gap_len());
    end
    // words after the merge has finished
    repeat ($urandom_range(0, 2)) begin
      send_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), {$urandom, $urandom});
      rest(gap_len());
    end
  endtask

  initial begin
    int unsigned r;
    bit          paused;
    logic [3:0]  value;
    sb = new();
    words_sent = 0;
    cfg_writes = 0;
    paused = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (10) @(negedge clk);
    rst = 0;

    // two streams after reset: ties, full slot, unused and ended streams, done
    send_word(kwsm_pkg::OP_RECORD, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(kwsm_pkg::OP_RECORD, 3'd0, 64'h1);
    send_word(kwsm_pkg::OP_RECORD, 3'd2, 64'h5);
    send_word(kwsm_pkg::OP_END,    3'd7, 64'h0);
    send_word(kwsm_pkg::OP_RECORD, 3'd1, 64'h0);
    rest(3);
    send_word(kwsm_pkg::OP_RECORD, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(kwsm_pkg::OP_END,    3'd0, 64'h0);
    send_word(kwsm_pkg::OP_END,    3'd0, 64'h0);
    send_word(kwsm_pkg::OP_END,    3'd1, 64'h0);
    send_word(kwsm_pkg::OP_RECORD, 3'd1, 64'h2);

    write_count(4'd8);
    send_word(kwsm_pkg::OP_RECORD, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(kwsm_pkg::OP_RECORD, 3'd6, 64'h8000_0000_0000_0000);
    send_word(kwsm_pkg::OP_RECORD, 3'd5, 64'h5);
    send_word(kwsm_pkg::OP_RECORD, 3'd4, 64'h5);
    send_word(kwsm_pkg::OP_END,    3'd3, 64'h0);
    send_word(kwsm_pkg::OP_RECORD, 3'd2, 64'h1);
    send_word(kwsm_pkg::OP_RECORD, 3'd1, 64'h1);
    send_word(kwsm_pkg::OP_RECORD, 3'd0, 64'h7FFF_FFFF_FFFF_FFFF);

    // zero acts as one stream
    write_count(4'd0);
    send_word(kwsm_pkg::OP_RECORD, 3'd0, 64'h0123_4567_89AB_CDEF);
    send_word(kwsm_pkg::OP_RECORD, 3'd1, 64'h0);
    send_word(kwsm_pkg::OP_END,    3'd0, 64'h0);

    // above the maximum acts as eight
    write_count(4'd15);
    send_word(kwsm_pkg::OP_RECORD, 3'd7, 64'h42);
    rest(1);

    while (words_sent < ITEMS) begin
      r = $urandom_range(0, 9);
      value = (r < 2) ? 4'd1 : (r < 4) ? 4'd8 : 4'($urandom_range(0, 15));
      write_count(value);
      run_merge($urandom_range(0, 3) == 0);
      if (!paused && words_sent > ITEMS / 2) begin
        drain();
        paused = 1;
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (sb.pending_q.size() != 0) begin
      $error("%0d expected result words never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("%0d input words over %0d stream-count settings", words_sent, cfg_writes);
    $display("results: %0d merged records, %0d done, %0d protocol errors",
             sb.n_records, sb.n_dones, sb.n_faults);
    if (sb.errors == 0) begin
      $display("tb_kway_sorted_record_merge: done, clean");
    end else begin
      $display("tb_kway_sorted_record_merge: done, errors");
    end
    $finish;
  end

endmodule

/* kway_sorted_record_merge.f */
design/kwsm_pkg.sv
design/kwsm_cell.sv
design/kway_sorted_record_merge.sv
tb/tb_kway_sorted_record_merge.sv
